FILE: rtl/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher block.
// No dependencies; rc4_stream_cipher_top, rc4_key_regs and rc4_core import this package.
`default_nettype none

package rc4_pkg;

    localparam int STATE_ENTRIES = 256;
    localparam int IDX_W         = 8;
    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_IDX_W     = 4;
    localparam int KEY_LEN_W     = 5;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LOW  = 2'd0,
        CFG_KEY_HIGH = 2'd1,
        CFG_KEY_LEN  = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_RD_A,
        ST_KS_RD_B,
        ST_KS_WR_A,
        ST_KS_WR_B,
        ST_PR_RD_I,
        ST_PR_RD_J,
        ST_PR_WR_I,
        ST_PR_WR_J,
        ST_PR_RD_K,
        ST_PR_OUT
    } rc4_state_t;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       last_idx;
    } rc4_key_t;

endpackage

`default_nettype wire

FILE: rtl/rc4_stream_cipher_top.sv
// Top level of the RC4 stream cipher: key registers plus the cipher sequencer.
// Depends on rc4_pkg, rc4_key_regs, rc4_core.
//
//   channel | signals                                       | transfer when
//   in      | in_valid, in_ready, data_in, last_of_message  | in_valid && in_ready
//   out     | out_valid, out_ready, data_out                | out_valid && out_ready
//   cfg     | cfg_write_en, cfg_index, cfg_data             | cfg_write_en
//
// A byte passes from input transfer to the output register through ST_PR_RD_I,
// ST_PR_RD_J, ST_PR_WR_I, ST_PR_WR_J, ST_PR_RD_K and ST_PR_OUT, the sequence of
// state RAM reads and writes; the input is ready once the result is loaded.
// The first byte of a message adds the state fill and the key schedule.
// Reset leaves the block idle with a schedule pending; the state RAM is not cleared.
// The input is not ready while a byte is in work; a stalled result holds only
// its own finishing step.
`default_nettype none

module rc4_stream_cipher_top
    import rc4_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            data_in,
    input  wire logic                  last_of_message,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [7:0]            data_out,
    input  wire logic                  cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    rc4_key_t             key_info;
    logic [KEY_IDX_W-1:0] key_idx;

    rc4_key_regs u_key_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .key_idx      (key_idx),
        .key_info     (key_info)
    );

    rc4_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_in         (data_in),
        .last_of_message (last_of_message),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .data_out        (data_out),
        .key_info        (key_info),
        .key_idx         (key_idx)
    );

endmodule

`default_nettype wire

FILE: rtl/rc4_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/rc4_key_regs.sv
// Key configuration registers and cyclic key byte selection.
// Depends on rc4_pkg.
`default_nettype none

module rc4_key_regs
    import rc4_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [KEY_IDX_W-1:0]  key_idx,
    output rc4_key_t                   key_info
);

    logic [CFG_DATA_W-1:0]  key_low_reg;
    logic [CFG_DATA_W-1:0]  key_high_reg;
    logic [KEY_LEN_W-1:0]   key_len_reg;
    logic [KEY_LEN_W-1:0]   used_len;
    logic [2*CFG_DATA_W-1:0] key_all;
    logic [KEY_LEN_W-1:0]   idx_plus;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= KEY_LEN_W'(1);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LEN:  key_len_reg  <= cfg_data[KEY_LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        if (key_len_reg == '0)
        begin
            used_len = KEY_LEN_W'(1);
        end
        else if (key_len_reg > KEY_LEN_W'(MAX_KEY_BYTES))
        begin
            used_len = KEY_LEN_W'(MAX_KEY_BYTES);
        end
        else
        begin
            used_len = key_len_reg;
        end
    end

    assign key_all           = {key_high_reg, key_low_reg};
    assign idx_plus          = {1'b0, key_idx} + KEY_LEN_W'(1);
    assign key_info.key_byte = key_all[{key_idx, 3'b000} +: 8];
    assign key_info.last_idx = (idx_plus == used_len);

endmodule

`default_nettype wire

FILE: rtl/rc4_core.sv
// RC4 sequencer: key schedule and keystream generation over one shared state RAM.
// Depends on rc4_pkg and rc4_ram.
`default_nettype none

module rc4_core
    import rc4_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           data_in,
    input  wire logic                 last_of_message,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [7:0]           data_out,
    input  rc4_key_t                  key_info,
    output logic      [KEY_IDX_W-1:0] key_idx
);

    rc4_state_t           state_reg, state_next;
    logic [IDX_W-1:0]     a_reg, a_next;
    logic [IDX_W-1:0]     b_reg, b_next;
    logic [KEY_IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0]     i_reg, i_next;
    logic [IDX_W-1:0]     j_reg, j_next;
    logic [IDX_W-1:0]     sa_reg, sa_next;
    logic [IDX_W-1:0]     sb_reg, sb_next;
    logic                 need_reg, need_next;
    logic                 last_reg, last_next;
    logic [7:0]           din_reg, din_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           dout_reg, dout_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [IDX_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [IDX_W-1:0]     ram_rdata;

    logic                 in_xfer;
    logic                 out_load;
    logic [IDX_W-1:0]     b_calc;
    logic [IDX_W-1:0]     j_calc;

    rc4_ram #(
        .WIDTH (IDX_W),
        .DEPTH (STATE_ENTRIES)
    ) u_sbox (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_load  = (state_reg == ST_PR_OUT) && (!out_valid_reg || out_ready);
    assign b_calc    = b_reg + ram_rdata + key_info.key_byte;
    assign j_calc    = j_reg + ram_rdata;
    assign key_idx   = k_reg;
    assign out_valid = out_valid_reg;
    assign data_out  = dout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            a_reg         <= '0;
            b_reg         <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            need_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            need_reg      <= need_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg   <= sa_next;
        sb_reg   <= sb_next;
        last_reg <= last_next;
        din_reg  <= din_next;
        dout_reg <= dout_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = need_reg ? ST_FILL : ST_PR_RD_I;
                end
            end
            ST_FILL:    state_next = (a_reg == '1) ? ST_KS_RD_A : ST_FILL;
            ST_KS_RD_A: state_next = ST_KS_RD_B;
            ST_KS_RD_B: state_next = ST_KS_WR_A;
            ST_KS_WR_A: state_next = ST_KS_WR_B;
            ST_KS_WR_B: state_next = (a_reg == '1) ? ST_PR_RD_I : ST_KS_RD_A;
            ST_PR_RD_I: state_next = ST_PR_RD_J;
            ST_PR_RD_J: state_next = ST_PR_WR_I;
            ST_PR_WR_I: state_next = ST_PR_WR_J;
            ST_PR_WR_J: state_next = ST_PR_RD_K;
            ST_PR_RD_K: state_next = ST_PR_OUT;
            ST_PR_OUT:  state_next = out_load ? ST_IDLE : ST_PR_OUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        need_next      = need_reg;
        last_next      = last_reg;
        din_next       = din_reg;
        dout_next      = dout_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_we         = 1'b0;
        ram_waddr      = a_reg;
        ram_wdata      = a_reg;
        ram_raddr      = a_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    din_next  = data_in;
                    last_next = last_of_message;
                    if (need_reg)
                    begin
                        a_next = '0;
                        b_next = '0;
                        k_next = '0;
                    end
                end
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
                a_next = a_reg + IDX_W'(1);
            end
            ST_KS_RD_A:
            begin
                ram_raddr = a_reg;
            end
            ST_KS_RD_B:
            begin
                sa_next   = ram_rdata;
                b_next    = b_calc;
                ram_raddr = b_calc;
            end
            ST_KS_WR_A:
            begin
                ram_we    = 1'b1;
                ram_waddr = a_reg;
                ram_wdata = ram_rdata;
            end
            ST_KS_WR_B:
            begin
                ram_we    = 1'b1;
                ram_waddr = b_reg;
                ram_wdata = sa_reg;
                a_next    = a_reg + IDX_W'(1);
                k_next    = key_info.last_idx ? '0 : k_reg + KEY_IDX_W'(1);
                if (a_reg == '1)
                begin
                    i_next    = '0;
                    j_next    = '0;
                    need_next = 1'b0;
                end
            end
            ST_PR_RD_I:
            begin
                i_next    = i_reg + IDX_W'(1);
                ram_raddr = i_reg + IDX_W'(1);
            end
            ST_PR_RD_J:
            begin
                sa_next   = ram_rdata;
                j_next    = j_calc;
                ram_raddr = j_calc;
            end
            ST_PR_WR_I:
            begin
                sb_next   = ram_rdata;
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = ram_rdata;
            end
            ST_PR_WR_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = sa_reg;
            end
            ST_PR_RD_K:
            begin
                ram_raddr = sa_reg + sb_reg;
            end
            ST_PR_OUT:
            begin
                ram_raddr = sa_reg + sb_reg;
                if (out_load)
                begin
                    dout_next      = din_reg ^ ram_rdata;
                    out_valid_next = 1'b1;
                    if (last_reg)
                    begin
                        need_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/rc4_checker.sv
// Port-level checks for the RC4 stream cipher top level, bound to it below.
// Depends on rc4_stream_cipher_top port list only.
`default_nettype none

module rc4_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] data_out
);

    a_reset_no_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid during reset");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input ready too soon after a transfer");

    a_no_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (!out_valid || out_ready) |=> !out_valid)
        else $error("result appeared without processing time");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_out))
        else $error("stalled result dropped or changed");

endmodule

bind rc4_stream_cipher_top rc4_checker u_rc4_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_out  (data_out)
);

`default_nettype wire

FILE: dv/rc4_stream_cipher_top_tb.sv
// Self-checking testbench for rc4_stream_cipher_top: byte-wise RC4 encryption with key
// registers. Depends on rc4_pkg and the RTL top; carries its own RC4 keystream predictor.
module rc4_stream_cipher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rc4_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int PHASE_BYTES    = 80;
    localparam int HOLD_CYCLES    = 2000;
    localparam int END_SLACK      = 32;
    localparam int TIMEOUT_CYCLES = 4_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam logic [7:0] KAT_TEXT [9] =
        '{8'h50, 8'h6C, 8'h61, 8'h69, 8'h6E, 8'h74, 8'h65, 8'h78, 8'h74};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cipher_byte_t;

    logic                  clk             = 1'b0;
    logic                  rst_n           = 1'b0;
    logic                  in_valid        = 1'b0;
    logic                  in_ready;
    logic [7:0]            data_in         = '0;
    logic                  last_of_message = 1'b0;
    logic                  out_valid;
    logic                  out_ready       = 1'b0;
    logic [7:0]            data_out;
    logic                  cfg_write_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [CFG_DATA_W-1:0] cfg_data        = '0;

    // keystream predictor state
    logic [CFG_DATA_W-1:0] key_lo        = '0;
    logic [CFG_DATA_W-1:0] key_hi        = '0;
    logic [KEY_LEN_W-1:0]  key_len       = 5'd1;
    logic [7:0]            sbox [STATE_ENTRIES];
    logic [7:0]            ks_i          = '0;
    logic [7:0]            ks_j          = '0;
    logic                  rekey_pending = 1'b1;

    cipher_byte_t plain_q [$];
    logic [7:0]   cipher_q [$];
    cipher_byte_t next_byte;
    logic [7:0]   want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int errors         = 0;
    int checked        = 0;
    int schedules      = 0;

    rc4_stream_cipher_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_in         (data_in),
        .last_of_message (last_of_message),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .data_out        (data_out),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic logic [7:0] next_cipher_byte(input logic [7:0] din, input logic last);
        int           n;
        logic [7:0]   b;
        logic [7:0]   t;
        logic [127:0] key_all;
        if (rekey_pending)
        begin
            n = int'(key_len);
            if (n == 0)
                n = 1;
            if (n > MAX_KEY_BYTES)
                n = MAX_KEY_BYTES;
            key_all = {key_hi, key_lo};
            for (int a = 0; a < STATE_ENTRIES; a++)
                sbox[a] = a[7:0];
            b = '0;
            for (int a = 0; a < STATE_ENTRIES; a++)
            begin
                b = b + sbox[a] + key_all[8*(a % n) +: 8];
                t = sbox[a];
                sbox[a] = sbox[b];
                sbox[b] = t;
            end
            ks_i = '0;
            ks_j = '0;
            rekey_pending = 1'b0;
            schedules++;
        end
        ks_i = ks_i + 8'd1;
        ks_j = ks_j + sbox[ks_i];
        t = sbox[ks_i];
        sbox[ks_i] = sbox[ks_j];
        sbox[ks_j] = t;
        if (last)
            rekey_pending = 1'b1;
        t = sbox[ks_i] + sbox[ks_j];
        return din ^ sbox[t];
    endfunction

    // input driver: predicts at each accepted transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                cipher_q.push_back(next_cipher_byte(data_in, last_of_message));
            if (!in_valid || in_ready)
            begin
                if (plain_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_byte = plain_q.pop_front();
                    in_valid        <= 1'b1;
                    data_in         <= next_byte.data;
                    last_of_message <= next_byte.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output ready with random stalls and an occasional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (cipher_q.size() == 0)
            begin
                errors++;
                $display("%0t data_out: expected none, got %02h", $time, data_out);
            end
            else
            begin
                want = cipher_q.pop_front();
                checked++;
                if (data_out !== want)
                begin
                    errors++;
                    $display("%0t data_out: expected %02h, got %02h", $time, want, data_out);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic l);
        plain_q.push_back({d, l});
    endtask

    task automatic queue_message(input int len, input bit close);
        cipher_byte_t it;
        for (int k = 0; k < len; k++)
        begin
            it.data = 8'($urandom_range(255));
            it.last = close && (k == len - 1);
            plain_q.push_back(it);
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        if (idx == CFG_KEY_LOW)
            key_lo = val;
        else if (idx == CFG_KEY_HIGH)
            key_hi = val;
        else if (idx == CFG_KEY_LEN)
            key_len = val[KEY_LEN_W-1:0];
    endtask

    task automatic cfg_idle();
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        while (plain_q.size() != 0 || in_valid || cipher_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int queued;
        int len;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset key: one zero byte
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();

        cfg_write(CFG_KEY_LOW, '1);
        cfg_write(CFG_KEY_HIGH, '1);
        cfg_write(CFG_KEY_LEN, 64'd16);
        cfg_idle();
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();

        // zero length acts as one byte
        cfg_write(CFG_KEY_LOW, 64'h1);
        cfg_write(CFG_KEY_LEN, 64'd0);
        cfg_idle();
        send_byte(8'h00, 1'b1);
        drain();

        // oversized length saturates
        cfg_write(CFG_KEY_LOW, {$urandom, $urandom});
        cfg_write(CFG_KEY_HIGH, {$urandom, $urandom});
        cfg_write(CFG_KEY_LEN, 64'd31);
        cfg_idle();
        queue_message(3, 1'b1);
        drain();

        // key rewritten mid-message only applies to the next message
        cfg_write(CFG_KEY_LEN, 64'd5);
        cfg_idle();
        queue_message(2, 1'b0);
        drain();
        cfg_write(CFG_KEY_LOW, {$urandom, $urandom});
        cfg_idle();
        queue_message(2, 1'b1);
        drain();

        // unmapped index is dropped; RC4 test key "Key" on "Plaintext"
        cfg_write(CFG_UNMAPPED, '1);
        cfg_write(CFG_KEY_LOW, 64'h0000_0000_0079_654B);
        cfg_write(CFG_KEY_HIGH, '0);
        cfg_write(CFG_KEY_LEN, 64'd3);
        cfg_idle();
        for (int k = 0; k < 9; k++)
            send_byte(KAT_TEXT[k], k == 8);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
                3:       begin send_idle_pct = 17; recv_stall_pct = 17; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            cfg_write(CFG_KEY_LOW, {$urandom, $urandom});
            cfg_write(CFG_KEY_HIGH, {$urandom, $urandom});
            if ($urandom_range(4) == 0)
                cfg_write(CFG_KEY_LEN, 64'($urandom_range(31)));
            else
                cfg_write(CFG_KEY_LEN, 64'($urandom_range(16, 1)));
            cfg_idle();
            if (p == 4)
                hold_req++;
            queued = 0;
            while (queued < PHASE_BYTES)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
                queued += len;
                queue_message(len, (queued < PHASE_BYTES) || ($urandom_range(1) == 1));
            end
            drain();
        end

        repeat (END_SLACK) @(posedge clk);
        $display("Summary: %0d bytes checked over %0d key schedules; five flow-control phases",
                 checked, schedules);
        $display("         including a %0d-cycle output hold-off with the input backed up",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("[rc4_stream_cipher_top] OK");
        else
            $display("[rc4_stream_cipher_top] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("%0t timeout with %0d results outstanding", $time, cipher_q.size());
        $display("[rc4_stream_cipher_top] ERROR");
        $finish;
    end

endmodule
